### src/mf3_pkg.sv
package mf3_pkg;

    // defaults for the top level parameters
    localparam int MAX_SIDE_DEF   = 128;
    localparam int PIXEL_BITS_DEF = 8;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // side register
    localparam int          SIDE_BITS  = 8;
    localparam logic [7:0]  SIDE_MIN   = 8'd3;
    localparam logic [7:0]  SIDE_RESET = 8'd3;

    // window edge: first row and column that give a result
    localparam int WIN_EDGE = 2;

    function automatic logic [31:0] max2(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

### src/mf3_front.sv
module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int DEPTH      = QUEUE_DEPTH,
    localparam int CW  = $clog2(MAX_SIDE),
    localparam int QCW = $clog2(DEPTH + 1),
    localparam int EW  = 3 * PIXEL_BITS + 2 * CW + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SIDE_BITS-1:0]  i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [QCW-1:0]        i_q_count,
    output logic                  o_push,
    output logic [EW-1:0]         o_push_data
);

    localparam int LW       = (CW > SIDE_BITS) ? CW : SIDE_BITS;
    localparam int SIDE_CAP = (MAX_SIDE > 255) ? 255 : MAX_SIDE;
    localparam int PB       = PIXEL_BITS;

    logic [SIDE_BITS-1:0] r_side;
    logic [CW-1:0]        r_col, r_row;
    logic [CW-1:0]        n_col, n_row;
    logic [SIDE_BITS-1:0] w_side, w_side_m1;
    logic                 w_accept, w_prod, w_last, w_col_end, w_row_end;

    // line buffers: word holds {line above, line two above}
    logic [2*PB-1:0] r_mem [MAX_SIDE];
    logic [2*PB-1:0] r_rd;

    // stage after the buffer read
    logic          r_s1_valid, r_s1_prod, r_s1_last;
    logic [PB-1:0] r_s1_pix;
    logic [CW-1:0] r_s1_col, r_s1_row;

    // column maxima of the two older window columns
    logic [PB-1:0] r_w0, r_w1;
    logic [PB-1:0] w_above, w_two, w_cm;

    // clamp the side to the supported range
    always_comb begin
        if (r_side < SIDE_MIN) begin
            w_side = SIDE_MIN;
        end else if (r_side > SIDE_BITS'(SIDE_CAP)) begin
            w_side = SIDE_BITS'(SIDE_CAP);
        end else begin
            w_side = r_side;
        end
    end
    assign w_side_m1 = w_side - SIDE_BITS'(1);

    assign w_col_end = (LW'(r_col) == LW'(w_side_m1));
    assign w_row_end = (LW'(r_row) == LW'(w_side_m1));
    assign w_prod    = (r_col >= CW'(WIN_EDGE)) && (r_row >= CW'(WIN_EDGE));
    assign w_last    = w_col_end && w_row_end;

    // credit: queued words plus the one that may still be pushed
    assign o_ready  = ((QCW+1)'(i_q_count) + (QCW+1)'(r_s1_valid & r_s1_prod))
                      < (QCW+1)'(DEPTH);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_col_end) begin
                n_col = '0;
                n_row = w_row_end ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= SIDE_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (i_cfg_we) begin
                r_side <= i_cfg_data;
                r_col  <= '0;
                r_row  <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix  <= i_pixel;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_prod <= w_prod;
            r_s1_last <= w_last;
        end
    end

    // buffer read on accept, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_mem[r_col];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= {r_s1_pix, w_above};
        end
    end

    assign w_above = r_rd[2*PB-1:PB];
    assign w_two   = r_rd[PB-1:0];
    assign w_cm    = PB'(max2(32'(max2(32'(w_two), 32'(w_above))), 32'(r_s1_pix)));

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_w0 <= r_w1;
            r_w1 <= w_cm;
        end
    end

    assign o_push      = r_s1_valid && r_s1_prod;
    assign o_push_data = {r_w0, r_w1, w_cm,
                          r_s1_row - CW'(WIN_EDGE),
                          r_s1_col - CW'(WIN_EDGE),
                          r_s1_last};

    a_last_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (o_push && o_push_data[0]))
        else $error("frame end word not pushed");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_count < QCW'(DEPTH)))
        else $error("push into full queue");

    a_border_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_prod) |=> !o_push)
        else $error("border pixel pushed a word");

endmodule

### src/mf3_fifo.sv
module mf3_fifo
    import mf3_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int QCW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic [QCW-1:0]   o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [QCW-1:0]   r_count;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

### src/mf3_back.sv
module mf3_back
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int CW         = 7,
    parameter int QCW        = 3,
    localparam int EW = 3 * PIXEL_BITS + 2 * CW + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [EW-1:0]         i_head,
    input  logic [QCW-1:0]        i_q_count,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_local_max,
    output logic [CW-1:0]         o_out_row,
    output logic [CW-1:0]         o_out_col,
    output logic                  o_frame_last
);

    localparam int PB = PIXEL_BITS;

    logic          r_valid;
    logic [PB-1:0] r_max;
    logic [CW-1:0] r_row, r_col;
    logic          r_last;
    logic [PB-1:0] w_a, w_b, w_c, w_max;

    assign {w_a, w_b, w_c} = i_head[EW-1:2*CW+1];
    assign w_max = PB'(max2(32'(max2(32'(w_a), 32'(w_b))), 32'(w_c)));

    // output register frees up when empty or taken this cycle
    assign o_pop = (i_q_count != '0) && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_max  <= w_max;
            r_row  <= i_head[2*CW:CW+1];
            r_col  <= i_head[CW:1];
            r_last <= i_head[0];
        end
    end

    assign o_valid      = r_valid;
    assign o_local_max  = r_max;
    assign o_out_row    = r_row;
    assign o_out_col    = r_col;
    assign o_frame_last = r_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |-> !o_pop)
        else $error("output word overwritten while stalled");

endmodule

### src/max_filter_3x3.sv
// channel | direction | handshake         | payload
// pixel   | in        | i_valid / o_ready | i_pixel
// result  | out       | o_valid / i_ready | o_local_max, o_out_row, o_out_col, o_frame_last
// config  | in        | i_cfg_we          | i_cfg_data (image side)
//
// one pixel per cycle while the queue has room; after its pixel is taken a result word
// passes the line buffer read, column maximum and queue write, and output register
// the line buffer memory has one read and one write port, read on accept and
// written back in the next cycle, which sets the one pixel per cycle figure
// synchronous active-low reset clears counters, queue and valid flags; the line
// buffers need no clearing pass, every entry is rewritten before a result uses it
// a stalled output holds its word while the four entry queue keeps taking pixels;
// o_ready drops once the queued words plus the word still on its way fill the queue
module max_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int CW = $clog2(MAX_SIDE)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [SIDE_BITS-1:0]  i_cfg_data,
    // pixel word in
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    // result word out
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_local_max,
    output logic [CW-1:0]         o_out_row,
    output logic [CW-1:0]         o_out_col,
    output logic                  o_frame_last
);

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    // queued word: three column maxima, row, column, frame end flag
    localparam int EW  = 3 * PIXEL_BITS + 2 * CW + 1;

    logic           w_push, w_pop;
    logic [EW-1:0]  w_push_data, w_head;
    logic [QCW-1:0] w_q_count;

    // front: counters, line buffers, window column maxima
    mf3_front #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS),
        .DEPTH      (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .i_q_count   (w_q_count),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // short queue so either side can stall alone
    mf3_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_count (w_q_count)
    );

    // back: final maximum over three columns and the output register
    mf3_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .QCW        (QCW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_count    (w_q_count),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_local_max  (o_local_max),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last)
    );

endmodule
